[sv/ffba_pkg.sv]
// Package for the first-fit block allocator: request/response structs,
// datapath command codes and status flags. No dependencies.
package ffba_pkg;

  localparam int unsigned HeapBlocksDef = 4096;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusNoFit   = 2'd1;
  localparam logic [1:0] StatusBadFree = 2'd2;

  localparam logic ModeAlloc = 1'b0;
  localparam logic ModeFree  = 1'b1;

  typedef struct packed {
    logic        mode;
    logic        owner;
    logic [11:0] block_count;
    logic [11:0] data_address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] granted_address;
  } rsp_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_CLR,
    DP_RD_P,
    DP_RD_H,
    DP_RD_NX,
    DP_STEP,
    DP_WR_SPLIT,
    DP_WR_ALLOC,
    DP_SAVE_H,
    DP_SAVE_NX,
    DP_WR_H,
    DP_WR_NX,
    DP_WR_PREV,
    DP_WR_HDEL
  } dp_cmd_e;

  typedef struct packed {
    logic clr_last;
    logic is_free;
    logic null_addr;
    logic h_in_heap;
    logic p_lt_heap;
    logic p_lt_h;
    logic fit;
    logic split;
    logic hdr_ok;
    logic nx_in;
    logic merge;
    logic prev_merge;
  } dp_stat_t;

endpackage

[sv/ffba_dp.sv]
// Datapath of the allocator: segment table memory, walk pointer and
// request registers. Executes one ffba_pkg command per cycle.
module ffba_dp #(
  parameter int unsigned HEAP_BLOCKS = ffba_pkg::HeapBlocksDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ffba_pkg::req_t    req_i,
  input  ffba_pkg::dp_cmd_e cmd_i,
  output ffba_pkg::dp_stat_t stat_o,
  output logic [11:0]       granted_o
);
  import ffba_pkg::*;

  localparam int unsigned AW = (HEAP_BLOCKS > 1) ? $clog2(HEAP_BLOCKS) : 1;
  localparam int unsigned LW = $clog2(HEAP_BLOCKS + 1);
  localparam int unsigned PW = ((LW > 13) ? LW : 13) + 1;
  localparam int unsigned WW = LW + 3;
  localparam logic [PW-1:0] Heap = PW'(HEAP_BLOCKS);

  // word: length, start, free, owner
  logic [WW-1:0] mem_q [HEAP_BLOCKS];
  logic [WW-1:0] rdata_q;

  req_t          req_q;
  logic [PW-1:0] p_q, prev_q, hlen_q, nx_q;
  logic [WW-1:0] prec_q, nrec_q;
  logic          havep_q, merge_q;
  logic [11:0]   granted_q;
  logic [AW-1:0] clr_q;

  logic [PW-1:0] need, h, rlen, step, nlen, plen, hsum;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [WW-1:0] wr_data;

  assign need = PW'(req_q.block_count) + PW'(1);
  assign h    = PW'(req_q.data_address) - PW'(1);
  assign rlen = PW'(rdata_q[WW-1:3]);
  assign step = (rlen == '0) ? PW'(1) : rlen;
  assign nlen = PW'(nrec_q[WW-1:3]);
  assign plen = PW'(prec_q[WW-1:3]);
  assign hsum = hlen_q + (merge_q ? nlen : '0);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = p_q[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = p_q[AW-1:0];
    wr_data = '0;
    case (cmd_i)
      DP_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = (clr_q == '0) ? {LW'(HEAP_BLOCKS), 3'b110} : '0;
      end
      DP_RD_P:  rd_en = 1'b1;
      DP_RD_H: begin
        rd_en   = 1'b1;
        rd_addr = h[AW-1:0];
      end
      DP_RD_NX: begin
        rd_en   = 1'b1;
        rd_addr = nx_q[AW-1:0];
      end
      DP_WR_SPLIT: begin
        wr_en   = 1'b1;
        wr_addr = AW'(p_q + need);
        wr_data = {LW'(rlen - need), 3'b110};
      end
      DP_WR_ALLOC: begin
        wr_en   = 1'b1;
        wr_data = {LW'(need), 2'b10, req_q.owner};
      end
      DP_WR_H: begin
        wr_en   = 1'b1;
        wr_addr = h[AW-1:0];
        wr_data = {LW'(hsum), 3'b110};
      end
      DP_WR_NX: begin
        wr_en   = 1'b1;
        wr_addr = nx_q[AW-1:0];
        wr_data = {LW'(0), 1'b0, nrec_q[1:0]};
      end
      DP_WR_PREV: begin
        wr_en   = 1'b1;
        wr_addr = prev_q[AW-1:0];
        wr_data = {LW'(plen + hlen_q), prec_q[2:0]};
      end
      DP_WR_HDEL: begin
        wr_en   = 1'b1;
        wr_addr = h[AW-1:0];
        wr_data = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      p_q       <= '0;
      havep_q   <= 1'b0;
      merge_q   <= 1'b0;
      granted_q <= '0;
    end else begin
      case (cmd_i)
        DP_CLR:  clr_q <= clr_q + AW'(1);
        DP_LOAD: begin
          req_q     <= req_i;
          p_q       <= '0;
          prev_q    <= '0;
          havep_q   <= 1'b0;
          granted_q <= '0;
        end
        DP_STEP: begin
          prev_q  <= p_q;
          prec_q  <= rdata_q;
          havep_q <= 1'b1;
          p_q     <= p_q + step;
        end
        DP_WR_ALLOC: granted_q <= 12'(p_q + PW'(1));
        DP_SAVE_H: begin
          hlen_q  <= rlen;
          nx_q    <= h + rlen;
          merge_q <= 1'b0;
        end
        DP_SAVE_NX: begin
          nrec_q  <= rdata_q;
          merge_q <= rdata_q[2] & rdata_q[1];
        end
        DP_WR_H: hlen_q <= hsum;
        default: ;
      endcase
    end
  end

  assign stat_o.clr_last   = (PW'(clr_q) == Heap - PW'(1));
  assign stat_o.is_free    = (req_q.mode == ModeFree);
  assign stat_o.null_addr  = (req_q.data_address == '0);
  assign stat_o.h_in_heap  = (h < Heap);
  assign stat_o.p_lt_heap  = (p_q < Heap);
  assign stat_o.p_lt_h     = (p_q < h);
  assign stat_o.fit        = rdata_q[2] & rdata_q[1] & (rlen >= need);
  assign stat_o.split      = (rlen > need);
  assign stat_o.hdr_ok     = rdata_q[2] & ~rdata_q[1] & (rdata_q[0] == req_q.owner);
  assign stat_o.nx_in      = (nx_q < Heap);
  assign stat_o.merge      = merge_q;
  assign stat_o.prev_merge = havep_q & prec_q[2] & prec_q[1] & ((prev_q + plen) == h);
  assign granted_o         = granted_q;

endmodule

[sv/ffba_ctrl.sv]
// Controller of the allocator: sequences datapath commands for the
// clearing pass, allocate walk and free/coalesce. Uses ffba_pkg.
module ffba_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  ffba_pkg::dp_stat_t stat_i,
  output ffba_pkg::dp_cmd_e  cmd_o,
  output logic               busy_o,
  output logic               done_o,
  output logic [1:0]         status_o
);
  import ffba_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISP, S_A_LOOP, S_A_CHK, S_A_WR,
    S_F_CHK, S_F_NX, S_F_NXCHK, S_F_WRH, S_F_WRNX, S_F_WALK,
    S_F_WSTEP, S_F_PREV, S_F_HDEL
  } state_e;

  state_e     state_q, state_d;
  logic       done_d;
  logic [1:0] status_q, status_d;
  logic       done_q;

  always_comb begin
    state_d  = state_q;
    cmd_o    = DP_NOP;
    done_d   = 1'b0;
    status_d = status_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o = DP_CLR;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o   = DP_LOAD;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        if (!stat_i.is_free) begin
          state_d = S_A_LOOP;
        end else if (stat_i.null_addr) begin
          done_d = 1'b1; status_d = StatusOk; state_d = S_IDLE;
        end else if (!stat_i.h_in_heap) begin
          done_d = 1'b1; status_d = StatusBadFree; state_d = S_IDLE;
        end else begin
          cmd_o   = DP_RD_H;
          state_d = S_F_CHK;
        end
      end
      S_A_LOOP: begin
        if (stat_i.p_lt_heap) begin
          cmd_o   = DP_RD_P;
          state_d = S_A_CHK;
        end else begin
          done_d = 1'b1; status_d = StatusNoFit; state_d = S_IDLE;
        end
      end
      S_A_CHK: begin
        if (stat_i.fit && stat_i.split) begin
          cmd_o   = DP_WR_SPLIT;
          state_d = S_A_WR;
        end else if (stat_i.fit) begin
          cmd_o  = DP_WR_ALLOC;
          done_d = 1'b1; status_d = StatusOk; state_d = S_IDLE;
        end else begin
          cmd_o   = DP_STEP;
          state_d = S_A_LOOP;
        end
      end
      S_A_WR: begin
        cmd_o  = DP_WR_ALLOC;
        done_d = 1'b1; status_d = StatusOk; state_d = S_IDLE;
      end
      S_F_CHK: begin
        if (!stat_i.hdr_ok) begin
          done_d = 1'b1; status_d = StatusBadFree; state_d = S_IDLE;
        end else begin
          cmd_o   = DP_SAVE_H;
          state_d = S_F_NX;
        end
      end
      S_F_NX: begin
        if (stat_i.nx_in) begin
          cmd_o   = DP_RD_NX;
          state_d = S_F_NXCHK;
        end else begin
          state_d = S_F_WRH;
        end
      end
      S_F_NXCHK: begin
        cmd_o   = DP_SAVE_NX;
        state_d = S_F_WRH;
      end
      S_F_WRH: begin
        cmd_o   = DP_WR_H;
        state_d = stat_i.merge ? S_F_WRNX : S_F_WALK;
      end
      S_F_WRNX: begin
        cmd_o   = DP_WR_NX;
        state_d = S_F_WALK;
      end
      S_F_WALK: begin
        if (stat_i.p_lt_h) begin
          cmd_o   = DP_RD_P;
          state_d = S_F_WSTEP;
        end else begin
          state_d = S_F_PREV;
        end
      end
      S_F_WSTEP: begin
        cmd_o   = DP_STEP;
        state_d = S_F_WALK;
      end
      S_F_PREV: begin
        if (stat_i.prev_merge) begin
          cmd_o   = DP_WR_PREV;
          state_d = S_F_HDEL;
        end else begin
          done_d = 1'b1; status_d = StatusOk; state_d = S_IDLE;
        end
      end
      S_F_HDEL: begin
        cmd_o  = DP_WR_HDEL;
        done_d = 1'b1; status_d = StatusOk; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      done_q   <= 1'b0;
      status_q <= StatusOk;
    end else begin
      state_q  <= state_d;
      done_q   <= done_d;
      status_q <= status_d;
    end
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign status_o = status_q;

endmodule

[sv/first_fit_block_allocator_top.sv]
// Channel   | Ports                 | Handshake
// request   | start, req_i          | accepted when start && !busy
// result    | done_o, rsp_o         | one-cycle strobe, cannot be stalled
//
// Allocate: walks the segments from block 0 to the first one that fits.
// Free: checks the header, merges a free next segment, walks the segments below
// the header (predecessor walk) and merges a free predecessor.
// After reset a clearing pass runs with busy high.
// Depends on ffba_pkg, ffba_ctrl, ffba_dp.
module first_fit_block_allocator_top #(
  parameter int unsigned HEAP_BLOCKS = ffba_pkg::HeapBlocksDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  ffba_pkg::req_t req_i,
  output logic           busy,
  output logic           done_o,
  output ffba_pkg::rsp_t rsp_o
);
  import ffba_pkg::*;

  dp_cmd_e  cmd;
  dp_stat_t stat;
  logic [1:0]  status;
  logic [11:0] granted;

  ffba_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .stat_i(stat), .cmd_o(cmd),
    .busy_o(busy), .done_o, .status_o(status)
  );

  ffba_dp #(.HEAP_BLOCKS(HEAP_BLOCKS)) u_dp (
    .clk_i, .rst_ni, .req_i, .cmd_i(cmd), .stat_o(stat), .granted_o(granted)
  );

  assign rsp_o.status          = status;
  assign rsp_o.granted_address = granted;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while busy");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("request not taken");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != StatusOk) |-> rsp_o.granted_address == '0)
    else $error("address on failure");
  a_cmd_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && !start) |-> cmd == DP_NOP) else $error("command while idle");

endmodule
